>>> rtl/bre_pkg.sv
// Shared types, codes and helper functions for the BER REAL encoder.
package bre_pkg;

  // Queue depth between the classify pipeline and the octet sequencer
  localparam int QUEUE_DEPTH = 2;

  // Field geometry of an IEEE double
  localparam int VALUE_W    = 64;
  localparam int FRAC_W     = 52;
  localparam int MANT_W     = 53;
  localparam int MANT_BYTES = 7;
  localparam int EXPO_W     = 12;
  localparam logic [10:0] EXP_ALL_ONES = 11'h7ff;
  localparam logic signed [EXPO_W-1:0] EXP_BIAS_SHIFT = 12'sd1075;
  localparam logic signed [EXPO_W-1:0] EXP_SUBNORMAL  = -12'sd1074;

  // Value classes
  localparam logic [1:0] KIND_FINITE = 2'd0;
  localparam logic [1:0] KIND_ZERO   = 2'd1;
  localparam logic [1:0] KIND_INF    = 2'd2;
  localparam logic [1:0] KIND_NAN    = 2'd3;

  // Fixed octets
  localparam logic [7:0] INF_POS_OCTET = 8'h40;
  localparam logic [7:0] INF_NEG_OCTET = 8'h41;
  localparam logic [7:0] INF_LEN_OCTET = 8'h01;
  localparam logic [7:0] BINARY_HEADER = 8'h80;

  // One classified value waiting for the octet sequencer
  typedef struct packed {
    logic [1:0]               kind;
    logic                     sign;
    logic                     elen2;   // exponent takes two octets
    logic [2:0]               mlen;    // mantissa octets, 1..7
    logic signed [EXPO_W-1:0] expo;
    logic [MANT_W-1:0]        mant;    // trailing zeros stripped
  } bre_item_t;

  // Position of the lowest set bit of a nonzero octet
  function automatic logic [2:0] bre_ctz8(input logic [7:0] b);
    logic [2:0] r;
    r = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (b[i]) r = 3'(i);
    end
    return r;
  endfunction

  // Position of the highest set bit of a nonzero octet
  function automatic logic [2:0] bre_msb8(input logic [7:0] b);
    logic [2:0] r;
    r = 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) r = 3'(i);
    end
    return r;
  endfunction

endpackage

>>> rtl/bre_front.sv
// Front end: classifies the double, strips trailing zeros, sizes the fields.
module bre_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [63:0]            in_value_bits,
  input  logic                   q_full,
  output logic                   q_push,
  output bre_pkg::bre_item_t     q_item
);
  import bre_pkg::*;

  // Stage 1: field split and per-octet bit positions
  logic                     s1_valid_r;
  logic [1:0]               s1_kind_r;
  logic                     s1_sign_r;
  logic [MANT_W-1:0]        s1_mant_r;
  logic signed [EXPO_W-1:0] s1_ebase_r;
  logic [MANT_BYTES-1:0]    s1_nz_r;
  logic [2:0]               s1_ctz_r [MANT_BYTES];
  logic [2:0]               s1_msb_r [MANT_BYTES];

  // Stage 2: trailing zero count and significant span
  logic                     s2_valid_r;
  logic [1:0]               s2_kind_r;
  logic                     s2_sign_r;
  logic [MANT_W-1:0]        s2_mant_r;
  logic signed [EXPO_W-1:0] s2_ebase_r;
  logic [5:0]               s2_tz_r;
  logic [5:0]               s2_span_r;

  logic        en1;
  logic        en2;
  logic [10:0] efield;
  logic [FRAC_W-1:0] frac;
  logic [1:0]  kind_in;
  logic [MANT_W-1:0] mant_in;
  logic [8*MANT_BYTES-1:0] mant_pad;
  logic [2:0]  lo_byte;
  logic [2:0]  hi_byte;
  logic [5:0]  tz;
  logic [5:0]  msb_pos;
  logic [6:0]  bit_len;
  logic signed [EXPO_W-1:0] expo;

  // Pipeline flow control
  assign q_push   = s2_valid_r && !q_full;
  assign en2      = !s2_valid_r || q_push;
  assign en1      = !s1_valid_r || en2;
  assign in_stall = !en1;

  // Classify the raw value
  assign efield  = in_value_bits[62:52];
  assign frac    = in_value_bits[FRAC_W-1:0];
  assign mant_in = {(efield != 11'd0), frac};
  assign mant_pad = {{(8*MANT_BYTES-MANT_W){1'b0}}, mant_in};

  always_comb begin
    if (efield == EXP_ALL_ONES) begin
      kind_in = (frac != '0) ? KIND_NAN : KIND_INF;
    end else if (efield == 11'd0 && frac == '0) begin
      kind_in = KIND_ZERO;
    end else begin
      kind_in = KIND_FINITE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en1) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_kind_r  <= kind_in;
      s1_sign_r  <= in_value_bits[63];
      s1_mant_r  <= mant_in;
      s1_ebase_r <= (efield == 11'd0) ? EXP_SUBNORMAL :
                    ($signed({1'b0, efield}) - EXP_BIAS_SHIFT);
      for (int b = 0; b < MANT_BYTES; b++) begin
        s1_nz_r[b]  <= (mant_pad[8*b +: 8] != 8'd0);
        s1_ctz_r[b] <= bre_ctz8(mant_pad[8*b +: 8]);
        s1_msb_r[b] <= bre_msb8(mant_pad[8*b +: 8]);
      end
    end
  end

  // Lowest and highest nonzero octets of the significand
  always_comb begin
    lo_byte = 3'd0;
    hi_byte = 3'd0;
    for (int b = MANT_BYTES - 1; b >= 0; b--) begin
      if (s1_nz_r[b]) lo_byte = 3'(b);
    end
    for (int b = 0; b < MANT_BYTES; b++) begin
      if (s1_nz_r[b]) hi_byte = 3'(b);
    end
  end

  assign tz      = {lo_byte, s1_ctz_r[lo_byte]};
  assign msb_pos = {hi_byte, s1_msb_r[hi_byte]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (en2) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_kind_r  <= s1_kind_r;
      s2_sign_r  <= s1_sign_r;
      s2_mant_r  <= s1_mant_r;
      s2_ebase_r <= s1_ebase_r;
      s2_tz_r    <= tz;
      s2_span_r  <= msb_pos - tz;
    end
  end

  // Strip, adjust exponent and size the octet fields
  assign bit_len = {1'b0, s2_span_r} + 7'd1;
  assign expo    = s2_ebase_r + $signed({6'd0, s2_tz_r});

  always_comb begin
    q_item.kind  = s2_kind_r;
    q_item.sign  = s2_sign_r;
    q_item.expo  = expo;
    q_item.elen2 = (expo < -12'sd128) || (expo > 12'sd127);
    q_item.mlen  = 3'(bit_len >> 3) + 3'd1;
    q_item.mant  = s2_mant_r >> s2_tz_r;
  end

endmodule

>>> rtl/bre_queue.sv
// Small FIFO that decouples the classify pipeline from the octet sequencer.
module bre_queue #(
  parameter int DEPTH = bre_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  bre_pkg::bre_item_t wr_item,
  input  logic               pop,
  output bre_pkg::bre_item_t rd_item,
  output logic               full,
  output logic               empty
);
  import bre_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  bre_item_t         mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [CNT_W-1:0]  count_r;
  logic [PTR_W-1:0]  wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_nxt;
  logic [CNT_W-1:0]  count_nxt;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign rd_item = mem_r[rd_ptr_r];

  // Pointer and occupancy update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule

>>> rtl/bre_back.sv
// Back end: walks one queued value out as octets, one per cycle unless out_stall holds.
module bre_back (
  input  logic               clk,
  input  logic               rst_n,
  input  bre_pkg::bre_item_t head,
  input  logic               q_empty,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_byte,
  output logic               out_last_byte,
  output logic               out_nan_error
);
  import bre_pkg::*;

  logic [3:0] idx_r;
  logic [3:0] idx_nxt;
  logic       out_valid_r;
  logic [7:0] byte_r;
  logic       last_r;
  logic       nan_r;

  logic       load;
  logic [7:0] byte_c;
  logic       last_c;
  logic       nan_c;
  logic [3:0] blen;
  logic [3:0] mant_start;
  logic [3:0] mant_pos;
  logic [2:0] mant_sel;
  logic [63:0] mant_pad;
  logic [7:0] mant_octet;
  logic [7:0] exp_hi;

  assign load  = !out_valid_r || !out_stall;
  assign q_pop = load && !q_empty && last_c;

  // Octet geometry of the value at the head of the queue
  assign blen       = 4'd2 + {3'd0, head.elen2} + {1'b0, head.mlen};
  assign mant_start = 4'd3 + {3'd0, head.elen2};
  assign mant_pos   = idx_r - mant_start;
  assign mant_sel   = head.mlen - 3'd1 - mant_pos[2:0];
  assign mant_pad   = {{(64-MANT_W){1'b0}}, head.mant};
  assign mant_octet = mant_pad[8*mant_sel +: 8];
  assign exp_hi     = {{4{head.expo[EXPO_W-1]}}, head.expo[EXPO_W-1:8]};

  // Octet at the current position
  always_comb begin
    byte_c = 8'd0;
    last_c = 1'b0;
    nan_c  = 1'b0;
    case (head.kind)
      KIND_NAN: begin
        last_c = 1'b1;
        nan_c  = 1'b1;
      end
      KIND_ZERO: begin
        last_c = 1'b1;
      end
      KIND_INF: begin
        if (idx_r == 4'd0) begin
          byte_c = INF_LEN_OCTET;
        end else begin
          byte_c = head.sign ? INF_NEG_OCTET : INF_POS_OCTET;
          last_c = 1'b1;
        end
      end
      KIND_FINITE: begin
        last_c = (idx_r == blen);
        if (idx_r == 4'd0) begin
          byte_c = {4'd0, blen};
        end else if (idx_r == 4'd1) begin
          byte_c = BINARY_HEADER | {1'b0, head.sign, 5'd0, head.elen2};
        end else if (idx_r == 4'd2 && head.elen2) begin
          byte_c = exp_hi;
        end else if (idx_r < mant_start) begin
          byte_c = head.expo[7:0];
        end else begin
          byte_c = mant_octet;
        end
      end
      default: begin
        byte_c = 8'd0;
      end
    endcase
  end

  // Position counter within the current value
  always_comb begin
    idx_nxt = idx_r;
    if (load && !q_empty) begin
      idx_nxt = last_c ? 4'd0 : idx_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      if (load) out_valid_r <= !q_empty;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= byte_c;
      last_r <= last_c;
      nan_r  <= nan_c;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_byte      = byte_r;
  assign out_last_byte = last_r;
  assign out_nan_error = nan_r;

endmodule

>>> rtl/ber_real_encoder.sv
// Path: a value passes the front-end stage registers, the queue and the output register.
// Throughput: one octet per cycle while out_stall is low; a value is 1 to 11 octets
// at the octet sequencer (1 for zero or NaN, 2 for infinity, 2 + exponent + mantissa
// octets otherwise), which sets the sustained input rate.
// Reset: synchronous, active low; clears pipeline valids, queue pointers and output valid.
module ber_real_encoder #(
  parameter int QUEUE_DEPTH = bre_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] in_value_bits,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_last_byte,
  output logic        out_nan_error
);
  import bre_pkg::*;

  bre_item_t push_item;
  bre_item_t head_item;
  logic      q_push;
  logic      q_pop;
  logic      q_full;
  logic      q_empty;

  bre_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_value_bits (in_value_bits),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_item        (push_item)
  );

  bre_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_item (push_item),
    .pop     (q_pop),
    .rd_item (head_item),
    .full    (q_full),
    .empty   (q_empty)
  );

  bre_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head          (head_item),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .out_last_byte (out_last_byte),
    .out_nan_error (out_nan_error)
  );

endmodule

>>> rtl/bre_checker.sv
// Port-level checks for the BER REAL encoder, bound to the top level.
module bre_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_byte,
  input logic        out_last_byte,
  input logic        out_nan_error
);

  // Nothing shows on the output right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  // The input side is ready right after reset
  a_reset_ready: assert property (@(posedge clk)
    !rst_n |=> !in_stall)
    else $error("input stalled right after reset");

  // A NaN item is a single zero octet
  a_nan_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_nan_error |-> out_last_byte && out_byte == 8'd0)
    else $error("NaN item is not a lone zero octet");

  // Octets of one value come without gaps
  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_byte |=> out_valid)
    else $error("gap inside a value's octets");

  // A stalled octet holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte) &&
      $stable(out_last_byte) && $stable(out_nan_error))
    else $error("stalled octet changed");

endmodule

bind ber_real_encoder bre_checker u_bre_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_byte      (out_byte),
  .out_last_byte (out_last_byte),
  .out_nan_error (out_nan_error)
);

>>> tb/tb.sv
// Self-checking testbench for the BER REAL encoder: directed and random doubles.
`timescale 1ns / 1ps

module tb;
  import bre_pkg::*;

  // Header bits of the binary REAL form
  localparam logic [7:0] HDR_NEG_SIGN  = 8'h40;
  localparam logic [7:0] HDR_EXP_2OCT  = 8'h01;
  localparam logic [7:0] NAN_OCTET     = 8'h00;
  localparam logic [7:0] ZERO_LEN      = 8'h00;
  localparam int         QUIET_TAIL    = 30;
  localparam int         RANDOM_VALUES = 300;

  typedef struct packed {
    logic [7:0] octet;
    logic       last;
    logic       nan;
  } ber_octet_t;

  typedef struct packed {
    logic [63:0] bits;
    logic        wait_drain;  // hold this item until all octets are out
  } double_item_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [63:0] in_value_bits = 64'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_byte;
  logic        out_last_byte;
  logic        out_nan_error;

  double_item_t pending_values[$];
  ber_octet_t   expected_octets[$];
  logic         in_taken = 1'b0;
  int           send_gap = 0;
  int           stall_left = 0;
  int           mismatches = 0;

  ber_real_encoder u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_value_bits(in_value_bits),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .out_last_byte(out_last_byte),
    .out_nan_error(out_nan_error)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Octets expected for one double, in transmission order
  function automatic void push_ber_octets(input logic [63:0] v);
    logic        neg;
    logic [10:0] efield;
    logic [51:0] frac;
    logic [63:0] mant;
    logic [15:0] eraw;
    logic [7:0]  body [0:9];
    int          expo;
    int          mlen;
    int          n;
    bit          short_exp;
    neg    = v[63];
    efield = v[62:52];
    frac   = v[51:0];
    if (efield == EXP_ALL_ONES && frac != 52'd0) begin
      expected_octets.push_back(ber_octet_t'{NAN_OCTET, 1'b1, 1'b1});
      return;
    end
    if (efield == EXP_ALL_ONES) begin
      expected_octets.push_back(ber_octet_t'{INF_LEN_OCTET, 1'b0, 1'b0});
      expected_octets.push_back(ber_octet_t'{neg ? INF_NEG_OCTET : INF_POS_OCTET, 1'b1, 1'b0});
      return;
    end
    if (efield == 11'd0 && frac == 52'd0) begin
      expected_octets.push_back(ber_octet_t'{ZERO_LEN, 1'b1, 1'b0});
      return;
    end
    // subnormals carry no implicit bit and use the smallest normal exponent
    if (efield == 11'd0) begin
      mant = {12'd0, frac};
      expo = 1 - int'(EXP_BIAS_SHIFT);
    end else begin
      mant = {11'd0, 1'b1, frac};
      expo = int'(efield) - int'(EXP_BIAS_SHIFT);
    end
    while (mant[0] == 1'b0) begin
      mant = mant >> 1;
      expo++;
    end
    // fewest octets with the top bit clear
    mlen = 1;
    while (mlen < 8 && mant > ((64'd1 << (8 * mlen - 1)) - 64'd1)) mlen++;
    short_exp = (expo >= -128 && expo <= 127);
    eraw = 16'(expo);
    n = 0;
    body[n] = BINARY_HEADER | (neg ? HDR_NEG_SIGN : 8'h00) | (short_exp ? 8'h00 : HDR_EXP_2OCT);
    n++;
    if (!short_exp) begin
      body[n] = eraw[15:8];
      n++;
    end
    body[n] = eraw[7:0];
    n++;
    for (int i = mlen - 1; i >= 0; i--) begin
      body[n] = 8'(mant >> (8 * i));
      n++;
    end
    expected_octets.push_back(ber_octet_t'{8'(n), 1'b0, 1'b0});
    for (int k = 0; k < n; k++) begin
      expected_octets.push_back(ber_octet_t'{body[k], k == n - 1, 1'b0});
    end
  endfunction

  // Random double, weighted toward classes and exponent boundaries
  function automatic logic [63:0] random_double();
    logic [51:0] frac;
    logic [10:0] efield;
    logic        sign;
    int          pick;
    int          sh;
    sign = 1'($urandom);
    frac = 52'({$urandom, $urandom});
    sh   = $urandom_range(0, 52);
    frac = (frac >> sh) << sh;
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      efield = 11'($urandom_range(1, 2046));
    end else if (pick < 66) begin
      // exponent near the one/two octet boundary
      efield = 11'($urandom_range(840, 1200));
    end else if (pick < 74) begin
      efield = 11'd0;
      if (frac == 52'd0) frac = 52'd1 << $urandom_range(0, 51);
    end else if (pick < 82) begin
      return {$urandom, $urandom};
    end else if (pick < 86) begin
      return {sign, 63'd0};
    end else if (pick < 90) begin
      return {sign, EXP_ALL_ONES, 52'd0};
    end else if (pick < 95) begin
      if (frac == 52'd0) frac = 52'd1 << $urandom_range(0, 51);
      efield = EXP_ALL_ONES;
    end else begin
      efield = 11'($urandom_range(1, 2046));
      frac = ($urandom_range(0, 1) == 0) ? 52'd0 : (52'd1 << $urandom_range(0, 51));
    end
    return {sign, efield, frac};
  endfunction

  // Sender: next item at the falling edge once the current one is taken
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_values.size() >= QUIET_TAIL && $urandom_range(0, 7) == 0) begin
        send_gap = $urandom_range(0, 14);
        in_valid <= 1'b0;
      end else if (pending_values.size() > 0 &&
                   (!pending_values[0].wait_drain || expected_octets.size() == 0)) begin
        in_valid      <= 1'b1;
        in_value_bits <= pending_values.pop_front().bits;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall bursts
  always @(negedge clk) begin
    if (rst_n) begin
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (pending_values.size() >= QUIET_TAIL && $urandom_range(0, 6) == 0) begin
        stall_left = $urandom_range(0, 14);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Accepted inputs feed the predictor; accepted octets are checked
  always @(posedge clk) begin
    if (rst_n) begin
      in_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) push_ber_octets(in_value_bits);
      if (out_valid && !out_stall) begin
        if (expected_octets.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected octet %02h last %0b nan %0b", $time,
                   out_byte, out_last_byte, out_nan_error);
        end else begin
          ber_octet_t want;
          want = expected_octets.pop_front();
          if (out_byte !== want.octet) begin
            mismatches++;
            $display("%0t: out_byte expected %02h actual %02h", $time, want.octet, out_byte);
          end
          if (out_last_byte !== want.last) begin
            mismatches++;
            $display("%0t: out_last_byte expected %0b actual %0b", $time, want.last,
                     out_last_byte);
          end
          if (out_nan_error !== want.nan) begin
            mismatches++;
            $display("%0t: out_nan_error expected %0b actual %0b", $time, want.nan,
                     out_nan_error);
          end
        end
      end
    end
  end

  // Directed values, then random ones with a few drain points
  initial begin
    logic [63:0] directed [$];
    directed = '{
      64'h0000000000000000, 64'h8000000000000000,  // zeros
      64'h7ff0000000000000, 64'hfff0000000000000,  // infinities
      64'h7ff0000000000001, 64'hfff8000000000000, 64'h7fffffffffffffff,  // NaNs
      64'h3ff0000000000000, 64'hbff0000000000000, 64'h3ff8000000000000,
      64'h3ff0000000000001, 64'hbfffffffffffffff,  // longest mantissa
      64'h7fefffffffffffff, 64'hffefffffffffffff,  // largest finite
      64'h0000000000000001, 64'h800fffffffffffff,  // subnormal extremes
      64'h0010000000000000,                        // smallest normal
      64'h47e0000000000000, 64'h47f0000000000000,  // E = 127 and 128
      64'h37f0000000000000, 64'h37e0000000000000,  // E = -128 and -129
      64'h405fc00000000000, 64'h4060200000000000   // mantissa 0x7f and 0x81
    };
    foreach (directed[i]) pending_values.push_back(double_item_t'{directed[i], 1'b0});
    for (int i = 0; i < RANDOM_VALUES; i++) begin
      pending_values.push_back(double_item_t'{random_double(), (i % 75) == 0});
    end
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    // all items sent and taken, then every predicted octet seen
    do begin
      @(posedge clk);
    end while (pending_values.size() != 0 || in_valid || expected_octets.size() != 0);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_octets.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  // Run limit
  initial begin
    #2000000;
    $display("tb failed");
    $finish;
  end

endmodule
